FILE: sv/pid_motor_position_drive_defines.svh
// Assertion macros for the PID motor position drive.
// Taken in by the top level; refers to its i_clk and i_rst_n.
`ifndef PID_MOTOR_POSITION_DRIVE_DEFINES_SVH
`define PID_MOTOR_POSITION_DRIVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pmpd_pkg.sv
// Shared types and constants of the PID motor position drive.
// No dependencies; imported by the top level.
package pmpd_pkg;

    // Number of fraction bits of the fixed-point gains.
    localparam int GAIN_FRAC_BITS = 24;

    localparam int GAIN_W    = 32;
    localparam int POS_W     = 32;
    localparam int DT_W      = 16;
    localparam int ERR_W     = POS_W + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int QUO_W     = DIFF_W - 1;
    localparam int INTEG_W   = 48;
    localparam int ISUM_W    = INTEG_W + 2;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int HI_SHIFT  = MUL_W;
    localparam int ACC_W     = 82;
    localparam int UMAG_W    = ACC_W - 1;
    localparam int DUTY_W    = 7;
    localparam int DIR_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 48;
    localparam int OUT_PAD   = OUT_W - (DIR_W + DUTY_W + ERR_W);
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100);

    localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // Drive direction codes.
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_PREP,
        ST_DIV_INIT,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_IMAG,
        ST_ABS,
        ST_DUTY
    } t_state;

    // Jobs of the shared multiplier, in issue order.
    typedef enum logic [2:0] {
        MOP_ERR_DT,
        MOP_P,
        MOP_D_LO,
        MOP_D_HI,
        MOP_I_LO,
        MOP_I_HI
    } t_mop;

endpackage

FILE: sv/pid_motor_position_drive.sv
// PID position drive for a DC motor: sequencer, serial divider, shared multiplier.
// Depends on pmpd_pkg and pid_motor_position_drive_defines.svh.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  position sample and elapsed time
//  m_axis    out        m_axis_tvalid / m_axis_tready  direction, duty and position error
//  cfg       in         i_cfg_wr_en (no back-pressure) gains, setpoint and duty limits
//
//  The input stays closed from a transfer until the item is finished. The 33-step
//  restoring divider for the derivative is followed by six jobs on the 32x32
//  multiplier. The result sits in an output register, so the next item is taken
//  while it waits; only a second finished result blocks on a stall.
//  Reset is synchronous and active low and restores the configuration, the state,
//  the integral, the previous error and the output valid flag.
`include "pid_motor_position_drive_defines.svh"

module pid_motor_position_drive
    import pmpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // s_axis_tdata fields, lowest bit up: encoder_pos[31:0], elapsed_ms[47:32]
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,
    // m_axis_tdata fields, lowest bit up: drive_direction[1:0], duty_percent[8:2],
    // position_error[41:9], zero padding[47:42]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata
);

    // Configuration registers.
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;
    logic [POS_W-1:0]  r_target;
    logic [DUTY_W-1:0] r_max_duty;
    logic [DUTY_W-1:0] r_min_duty;

    // Sequencer.
    t_state r_state;
    t_state n_state;
    t_mop   r_op;
    logic [CNT_W-1:0] r_cnt;

    // Working registers of one item.
    logic [POS_W-1:0]   r_pos;
    logic [DT_W-1:0]    r_dt;
    logic [ERR_W-1:0]   r_err;
    logic [ERR_W-1:0]   r_last_err;
    logic [MUL_W-1:0]   r_emag;
    logic [DIFF_W-1:0]  r_diff;
    logic [QUO_W-1:0]   r_quo;
    logic [DT_W-1:0]    r_rem;
    logic [INTEG_W-1:0] r_integ;
    logic [INTEG_W-1:0] r_imag;
    logic [PROD_W-1:0]  r_prod;
    logic               r_prod_neg;
    logic               r_prod_hi;
    logic [ACC_W-1:0]   r_acc;
    logic [UMAG_W-1:0]  r_umag;
    logic               r_u_neg;
    logic               r_u_zero;

    // Output register.
    logic               r_out_valid;
    logic [DIR_W-1:0]   r_out_dir;
    logic [DUTY_W-1:0]  r_out_duty;
    logic [ERR_W-1:0]   r_out_err;

    logic w_in_xfer;
    logic w_out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, r_out_err, r_out_duty, r_out_dir};

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= GAIN_W'(22649242);
            r_gain_i   <= GAIN_W'(168);
            r_gain_d   <= GAIN_W'(838861);
            r_target   <= '0;
            r_max_duty <= DUTY_FULL;
            r_min_duty <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_GAIN_P:   r_gain_p   <= i_cfg_wdata;
                CFG_GAIN_I:   r_gain_i   <= i_cfg_wdata;
                CFG_GAIN_D:   r_gain_d   <= i_cfg_wdata;
                CFG_TARGET:   r_target   <= i_cfg_wdata;
                CFG_MAX_DUTY: r_max_duty <= i_cfg_wdata[DUTY_W-1:0];
                CFG_MIN_DUTY: r_min_duty <= i_cfg_wdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Magnitudes of the signed working values.
    logic [ERR_W-1:0]  w_err_neg;
    logic [DIFF_W-1:0] w_diff_neg;
    logic [INTEG_W-1:0] w_integ_neg;
    logic [ACC_W-1:0]  w_acc_neg;

    assign w_err_neg   = -r_err;
    assign w_diff_neg  = -r_diff;
    assign w_integ_neg = -r_integ;
    assign w_acc_neg   = -r_acc;

    // One step of the restoring divider: the remainder stays below a nonzero divisor.
    logic [DT_W:0] w_trial;
    logic          w_fits;
    logic [DT_W:0] w_rem_next;
    logic [QUO_W-1:0] w_quo_next;

    assign w_trial    = {r_rem, r_quo[QUO_W-1]};
    assign w_fits     = (w_trial >= {1'b0, r_dt});
    assign w_rem_next = w_fits ? (w_trial - {1'b0, r_dt}) : w_trial;
    assign w_quo_next = {r_quo[QUO_W-2:0], w_fits};

    // Operand selection for the shared multiplier. Each job multiplies two
    // magnitudes; the sign and the 32-bit weight of the result travel alongside.
    logic [MUL_W-1:0] w_mul_a;
    logic [MUL_W-1:0] w_mul_b;
    logic             w_mul_neg;
    logic             w_mul_hi;

    always_comb begin
        w_mul_a   = r_gain_p;
        w_mul_b   = r_emag;
        w_mul_neg = r_err[ERR_W-1];
        w_mul_hi  = 1'b0;
        case (r_op)
            MOP_ERR_DT: begin
                w_mul_a = r_emag;
                w_mul_b = {{(MUL_W-DT_W){1'b0}}, r_dt};
            end
            MOP_P: begin
                w_mul_a = r_gain_p;
                w_mul_b = r_emag;
            end
            MOP_D_LO: begin
                w_mul_a   = r_gain_d;
                w_mul_b   = r_quo[MUL_W-1:0];
                w_mul_neg = r_diff[DIFF_W-1];
            end
            MOP_D_HI: begin
                w_mul_a   = r_gain_d;
                w_mul_b   = {{(2*MUL_W-QUO_W){1'b0}}, r_quo[QUO_W-1:MUL_W]};
                w_mul_neg = r_diff[DIFF_W-1];
                w_mul_hi  = 1'b1;
            end
            MOP_I_LO: begin
                w_mul_a   = r_gain_i;
                w_mul_b   = r_imag[MUL_W-1:0];
                w_mul_neg = r_integ[INTEG_W-1];
            end
            MOP_I_HI: begin
                w_mul_a   = r_gain_i;
                w_mul_b   = {{(2*MUL_W-INTEG_W){1'b0}}, r_imag[INTEG_W-1:MUL_W]};
                w_mul_neg = r_integ[INTEG_W-1];
                w_mul_hi  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Integral update: the error times elapsed time is below 2^48 in magnitude.
    logic [ISUM_W-1:0]  w_iprod;
    logic [ISUM_W-1:0]  w_isum;
    logic [INTEG_W-1:0] w_integ_sat;

    assign w_iprod = {2'b00, r_prod[INTEG_W-1:0]};
    assign w_isum  = {{2{r_integ[INTEG_W-1]}}, r_integ}
                   + (r_err[ERR_W-1] ? -w_iprod : w_iprod);

    always_comb begin
        if (w_isum[ISUM_W-1:INTEG_W-1] == '0 || w_isum[ISUM_W-1:INTEG_W-1] == '1) begin
            w_integ_sat = w_isum[INTEG_W-1:0];
        end else if (w_isum[ISUM_W-1]) begin
            w_integ_sat = INTEG_MIN;
        end else begin
            w_integ_sat = INTEG_MAX;
        end
    end

    // Weighted product term added into the control sum.
    logic [ACC_W-1:0] w_term;

    assign w_term = r_prod_hi ? {r_prod[ACC_W-HI_SHIFT-1:0], {HI_SHIFT{1'b0}}}
                              : {{(ACC_W-PROD_W){1'b0}}, r_prod};

    // Duty: whole part of the magnitude, capped, then floored while off target unless the control sum is zero.
    logic              w_over;
    logic [DUTY_W-1:0] w_raw;
    logic [DUTY_W-1:0] w_lim;
    logic [DUTY_W-1:0] w_cap;
    logic [DUTY_W-1:0] w_floor;
    logic [DUTY_W-1:0] w_capped;
    logic [DUTY_W-1:0] w_duty;
    logic [DIR_W-1:0]  w_dir;

    assign w_over   = |r_umag[UMAG_W-1:GAIN_FRAC_BITS+DUTY_W];
    assign w_raw    = r_umag[GAIN_FRAC_BITS+DUTY_W-1:GAIN_FRAC_BITS];
    assign w_lim    = (w_over || w_raw > DUTY_FULL) ? DUTY_FULL : w_raw;
    assign w_cap    = (r_max_duty > DUTY_FULL) ? DUTY_FULL : r_max_duty;
    assign w_floor  = (r_min_duty > DUTY_FULL) ? DUTY_FULL : r_min_duty;
    assign w_capped = (w_lim > w_cap) ? w_cap : w_lim;

    always_comb begin
        if (r_u_zero) begin
            w_dir  = DIR_STOP;
            w_duty = '0;
        end else begin
            w_dir  = r_u_neg ? DIR_CCW : DIR_CW;
            w_duty = (w_capped < w_floor && r_err != '0) ? w_floor : w_capped;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_ERR;
                end
            end
            ST_ERR:      n_state = ST_PREP;
            ST_PREP:     n_state = ST_DIV_INIT;
            ST_DIV_INIT: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:      n_state = ST_ACC;
            ST_ACC: begin
                if (r_op == MOP_ERR_DT) begin
                    n_state = ST_IMAG;
                end else if (r_op == MOP_I_HI) begin
                    n_state = ST_ABS;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_IMAG:     n_state = ST_MUL;
            ST_ABS:      n_state = ST_DUTY;
            ST_DUTY: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Item state kept across items: integral and previous error.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
        end else begin
            if (r_state == ST_PREP) begin
                r_last_err <= r_err;
            end
            if (r_state == ST_ACC && r_op == MOP_ERR_DT) begin
                r_integ <= w_integ_sat;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    r_pos <= s_axis_tdata[POS_W-1:0];
                    r_dt  <= s_axis_tdata[POS_W+DT_W-1:POS_W];
                end
            end
            ST_ERR: begin
                r_err <= {r_pos[POS_W-1], r_pos} - {r_target[POS_W-1], r_target};
                r_acc <= '0;
            end
            ST_PREP: begin
                r_emag <= r_err[ERR_W-1] ? w_err_neg[MUL_W-1:0] : r_err[MUL_W-1:0];
                r_diff <= {r_err[ERR_W-1], r_err} - {r_last_err[ERR_W-1], r_last_err};
            end
            ST_DIV_INIT: begin
                r_quo <= r_diff[DIFF_W-1] ? w_diff_neg[QUO_W-1:0] : r_diff[QUO_W-1:0];
                r_rem <= '0;
                r_cnt <= '0;
                r_op  <= MOP_ERR_DT;
            end
            ST_DIV: begin
                r_rem <= w_rem_next[DT_W-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
                // A zero elapsed time gives a zero derivative.
                if (r_cnt == CNT_W'(DIV_STEPS - 1) && r_dt == '0) begin
                    r_quo <= '0;
                end else begin
                    r_quo <= w_quo_next;
                end
            end
            ST_MUL: begin
                r_prod     <= w_mul_a * w_mul_b;
                r_prod_neg <= w_mul_neg;
                r_prod_hi  <= w_mul_hi;
            end
            ST_ACC: begin
                if (r_op != MOP_ERR_DT) begin
                    r_acc <= r_prod_neg ? (r_acc - w_term) : (r_acc + w_term);
                end
                r_op <= t_mop'(r_op + 3'd1);
            end
            ST_IMAG: begin
                r_imag <= r_integ[INTEG_W-1] ? w_integ_neg : r_integ;
            end
            ST_ABS: begin
                r_u_neg  <= r_acc[ACC_W-1];
                r_u_zero <= (r_acc == '0);
                r_umag   <= r_acc[ACC_W-1] ? w_acc_neg[UMAG_W-1:0] : r_acc[UMAG_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Output register: loaded when the last stage finishes and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DUTY && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DUTY && w_out_free) begin
            r_out_dir  <= w_dir;
            r_out_duty <= w_duty;
            r_out_err  <= r_err;
        end
    end

    // A transfer starts a long run; the input side stays closed the next cycle.
    `PMPD_ASSERT_NEXT(a_busy_after_transfer, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again right after a transfer")
    // A stopped result never carries a duty.
    `PMPD_ASSERT_NOW(a_stop_zero_duty, r_out_valid && r_out_dir == DIR_STOP, r_out_duty == '0, "stopped result with nonzero duty")
    // Duty stays within percent range.
    `PMPD_ASSERT_NOW(a_duty_range, r_out_valid, r_out_duty <= DUTY_FULL, "duty above full scale")

endmodule
